FILE: rtl/tmcw_pkg.sv
// Package for the text-mode console writer: screen geometry, character codes,
// action codes and the structs shared by the top level, the cursor logic and the cell RAM.
// No dependencies.
`timescale 1ns / 1ps

package tmcw_pkg;

    // Screen geometry.
    localparam int COLUMNS       = 80;
    localparam int ROWS          = 25;
    localparam int CELLS         = COLUMNS * ROWS;
    localparam int LAST_ROW_BASE = (ROWS - 1) * COLUMNS;

    // Derived widths.
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int COL_SUM_W = $clog2(COLUMNS + 8);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int ROW_SUM_W = $clog2(ROWS + 1);
    localparam int CELL_W    = 16;

    // Character and attribute codes.
    localparam logic [7:0] CH_BS      = 8'h08;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0a;
    localparam logic [7:0] CH_CR      = 8'h0d;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DEL     = 8'h7f;
    localparam logic [7:0] ATTR_FIRST = 8'h10;
    localparam logic [7:0] ATTR_LAST  = 8'h1f;
    localparam logic [7:0] ATTR_RESET = 8'h0f;

    // Action codes of an input item.
    localparam logic [1:0] ACT_PUT   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0] action;
        logic [7:0] byte_in;
        logic [4:0] cell_row;
        logic [6:0] cell_column;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [10:0] cursor_position;
        logic [7:0]  read_character;
        logic [7:0]  read_attribute;
    } t_out_item;

    // Request to the cell RAM: one write port and one read port.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    // Effect of one put byte on the cursor, the attribute and the screen.
    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [7:0]        attr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [CELL_W-1:0] wr_data;
        logic              rmw_en;
        logic              rmw_space;
        logic [ADDR_W-1:0] rmw_addr;
        logic              scroll;
    } t_put_plan;

endpackage

FILE: rtl/tmcw_ram.sv
// Cell RAM of the console: one word of character and attribute per screen cell.
// One write port and one read port, read data registered. Depends on tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_ram
    import tmcw_pkg::*;
(
    input  logic              i_clk,
    input  t_mem_req          i_req,
    output logic [CELL_W-1:0] o_rd_data
);

    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // Read port, read data registered.
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/tmcw_cursor.sv
// Decode of one put byte: new cursor, new attribute, the cell write and the
// read-modify-write that the byte needs. Purely combinational. Depends on tmcw_pkg.
`timescale 1ns / 1ps

module tmcw_cursor
    import tmcw_pkg::*;
(
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_row,
    input  logic [7:0]       i_attr,
    input  logic [7:0]       i_byte,
    output t_put_plan        o_plan
);

    logic [ADDR_W-1:0]    pos;
    logic [COL_SUM_W-1:0] col_inc;
    logic [COL_SUM_W-1:0] col_tab;
    logic [ROW_SUM_W-1:0] row_inc;
    logic [COL_SUM_W-1:0] n_col;
    logic [ROW_SUM_W-1:0] n_row;

    // Linear cell address of the cursor and the candidate moves.
    assign pos     = ADDR_W'(i_row) * ADDR_W'(COLUMNS) + ADDR_W'(i_col);
    assign col_inc = COL_SUM_W'(i_col) + COL_SUM_W'(1);
    assign col_tab = COL_SUM_W'({i_col[COL_W-1:3], 3'b000}) + COL_SUM_W'(8);
    assign row_inc = ROW_SUM_W'(i_row) + ROW_SUM_W'(1);

    always_comb begin
        n_col              = COL_SUM_W'(i_col);
        n_row              = ROW_SUM_W'(i_row);
        o_plan             = '0;
        o_plan.attr        = i_attr;
        o_plan.wr_addr     = pos;
        o_plan.wr_data     = {i_attr, i_byte};
        o_plan.rmw_addr    = pos + ADDR_W'(1);

        // Byte decode.
        if (i_byte >= CH_SPACE && i_byte < CH_DEL) begin
            // Printable: store it, and give the next cell the attribute too.
            o_plan.wr_en  = 1'b1;
            o_plan.rmw_en = (pos != ADDR_W'(CELLS - 1));
            n_col         = col_inc;
        end else if (i_byte == CH_LF) begin
            n_row = row_inc;
            n_col = '0;
        end else if (i_byte == CH_CR) begin
            n_col = '0;
        end else if (i_byte == CH_TAB) begin
            n_col = col_tab;
        end else if (i_byte == CH_BS) begin
            // Backspace at the left edge does nothing.
            if (i_col != '0) begin
                n_col            = COL_SUM_W'(i_col) - COL_SUM_W'(1);
                o_plan.rmw_en    = 1'b1;
                o_plan.rmw_space = 1'b1;
                o_plan.rmw_addr  = pos - ADDR_W'(1);
            end
        end else if (i_byte >= ATTR_FIRST && i_byte <= ATTR_LAST) begin
            o_plan.attr = i_byte - ATTR_FIRST;
        end

        // Column wrap to the start of the next row.
        if (n_col >= COL_SUM_W'(COLUMNS)) begin
            n_col = '0;
            n_row = row_inc;
        end

        // Past the last row: the screen scrolls and the cursor stays on the last row.
        o_plan.col    = n_col[COL_W-1:0];
        o_plan.scroll = (n_row > ROW_SUM_W'(ROWS - 1));
        o_plan.row    = o_plan.scroll ? ROW_W'(ROWS - 1) : n_row[ROW_W-1:0];
    end

endmodule

FILE: rtl/text_mode_console_writer.sv
// Text-mode console writer, top level: sequencer, cursor registers, result register.
// Instantiates tmcw_cursor and tmcw_ram. Depends on tmcw_pkg.
//
// Use: items enter on the in channel (i_in_valid / o_in_ready, payload i_in_data),
// one result per item leaves on the out channel (o_out_valid / i_out_ready,
// payload o_out_data). The scroll top row is written on the cfg channel, which is
// always ready; write it only while the block is idle.
// Items are taken one at a time and all share the single cell RAM:
//   - control or attribute byte, left-edge backspace, out-of-range read,
//     unused action: no RAM read, then the hand-over (S_DONE)
//   - printable, other backspace, read: a registered RAM read, then S_RMW/S_RDWAIT
//   - a put that scrolls, in addition: S_SCROLL0 primes a read, S_SCROLL copies the
//     rows below the top up one row, cell by cell; S_ZERO clears the last row
//   - clear: S_CLEAR zeroes every cell, one cell written per cycle
// The result register decouples the sides: the next item is taken while a result
// waits; if the receiver stalls, the following item finishes and then holds.
// After reset the block sweeps every RAM cell to zero and takes
// no item during the sweep; configuration transfers are taken throughout.
`timescale 1ns / 1ps

module text_mode_console_writer
    import tmcw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [4:0] i_cfg_data,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_RMW     = 8'b0000_0100,
        S_RDWAIT  = 8'b0000_1000,
        S_SCROLL0 = 8'b0001_0000,
        S_SCROLL  = 8'b0010_0000,
        S_ZERO    = 8'b0100_0000,
        S_DONE    = 8'b1000_0000
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_sweep, n_sweep;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [7:0]        r_attr, n_attr;
    logic [4:0]        r_top, n_top;
    logic              r_item, n_item;
    logic              r_scroll, n_scroll;
    logic              r_rmw_space, n_rmw_space;
    logic [ADDR_W-1:0] r_rmw_addr, n_rmw_addr;
    logic [7:0]        r_res_char, n_res_char;
    logic [7:0]        r_res_attr, n_res_attr;
    t_out_item         r_out, n_out;
    logic              r_out_valid, n_out_valid;

    t_put_plan         plan;
    t_mem_req          mem_req;
    logic [CELL_W-1:0] rd_data;
    logic [ADDR_W-1:0] top_base;
    logic [ADDR_W-1:0] read_addr;
    logic              read_in_range;
    logic              load_out;

    // Put byte decode.
    tmcw_cursor u_cursor (
        .i_col  (r_col),
        .i_row  (r_row),
        .i_attr (r_attr),
        .i_byte (i_in_data.byte_in),
        .o_plan (plan)
    );

    // Screen cells.
    tmcw_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Address helpers.
    assign top_base      = ADDR_W'(r_top) * ADDR_W'(COLUMNS);
    assign read_addr     = ADDR_W'(i_in_data.cell_row) * ADDR_W'(COLUMNS)
                         + ADDR_W'(i_in_data.cell_column);
    assign read_in_range = (32'(i_in_data.cell_row) < 32'(ROWS))
                        && (32'(i_in_data.cell_column) < 32'(COLUMNS));

    // Sequencer.
    always_comb begin
        n_state     = r_state;
        n_sweep     = r_sweep;
        n_col       = r_col;
        n_row       = r_row;
        n_attr      = r_attr;
        n_item      = r_item;
        n_scroll    = r_scroll;
        n_rmw_space = r_rmw_space;
        n_rmw_addr  = r_rmw_addr;
        n_res_char  = r_res_char;
        n_res_attr  = r_res_attr;
        mem_req     = '0;
        load_out    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_sweep;
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    n_state = r_item ? S_DONE : S_IDLE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end

            S_IDLE: begin
                if (i_in_valid) begin
                    n_res_char = '0;
                    n_res_attr = '0;
                    n_item     = 1'b1;
                    case (i_in_data.action)
                        ACT_PUT: begin
                            n_col           = plan.col;
                            n_row           = plan.row;
                            n_attr          = plan.attr;
                            n_scroll        = plan.scroll;
                            n_rmw_space     = plan.rmw_space;
                            n_rmw_addr      = plan.rmw_addr;
                            mem_req.wr_en   = plan.wr_en;
                            mem_req.wr_addr = plan.wr_addr;
                            mem_req.wr_data = plan.wr_data;
                            mem_req.rd_en   = plan.rmw_en;
                            mem_req.rd_addr = plan.rmw_addr;
                            if (plan.rmw_en) begin
                                n_state = S_RMW;
                            end else if (plan.scroll) begin
                                n_state = S_SCROLL0;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_READ: begin
                            if (read_in_range) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = read_addr;
                                n_state         = S_RDWAIT;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        ACT_CLEAR: begin
                            n_col   = '0;
                            n_row   = '0;
                            n_sweep = '0;
                            n_state = S_CLEAR;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            // Second half of the read-modify-write on a neighboring cell.
            S_RMW: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_rmw_addr;
                mem_req.wr_data = r_rmw_space ? {rd_data[15:8], CH_SPACE}
                                              : {r_attr, rd_data[7:0]};
                n_state         = r_scroll ? S_SCROLL0 : S_DONE;
            end

            S_RDWAIT: begin
                n_res_char = rd_data[7:0];
                n_res_attr = rd_data[15:8];
                n_state    = S_DONE;
            end

            // Scroll start: prime the read one row below the top row, else S_ZERO.
            S_SCROLL0: begin
                if (32'(r_top) < 32'(ROWS - 1)) begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = top_base + ADDR_W'(COLUMNS);
                    n_sweep         = top_base;
                    n_state         = S_SCROLL;
                end else begin
                    n_sweep = ADDR_W'(LAST_ROW_BASE);
                    n_state = S_ZERO;
                end
            end

            // Row copy: write the cell read last cycle, read the next one.
            S_SCROLL: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_sweep;
                mem_req.wr_data = rd_data;
                if (r_sweep == ADDR_W'(LAST_ROW_BASE - 1)) begin
                    n_sweep = ADDR_W'(LAST_ROW_BASE);
                    n_state = S_ZERO;
                end else begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = r_sweep + ADDR_W'(COLUMNS + 1);
                    n_sweep         = r_sweep + ADDR_W'(1);
                end
            end

            // Bottom row zeroed one cell a cycle.
            S_ZERO: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_sweep;
                if (r_sweep == ADDR_W'(CELLS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end

            // Hand the result over once the result register is free.
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_item   = 1'b0;
                    n_scroll = 1'b0;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Result register and configuration.
    always_comb begin
        n_out                 = r_out;
        n_out.cursor_position = 11'(ADDR_W'(r_row) * ADDR_W'(COLUMNS) + ADDR_W'(r_col));
        n_out.read_character  = r_res_char;
        n_out.read_attribute  = r_res_attr;
        if (!load_out) begin
            n_out = r_out;
        end

        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end

        n_top = i_cfg_valid ? i_cfg_data : r_top;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_attr      <= ATTR_RESET;
            r_top       <= '0;
            r_item      <= 1'b0;
            r_scroll    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_col       <= n_col;
            r_row       <= n_row;
            r_attr      <= n_attr;
            r_top       <= n_top;
            r_item      <= n_item;
            r_scroll    <= n_scroll;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rmw_space <= n_rmw_space;
        r_rmw_addr  <= n_rmw_addr;
        r_res_char  <= n_res_char;
        r_res_attr  <= n_res_attr;
        r_out       <= n_out;
    end

endmodule

FILE: dv/tb.sv
// Self-checking testbench for the text-mode console writer (text_mode_console_writer).
// Predicts screen, cursor and attribute in the testbench; depends on tmcw_pkg and the RTL only.
`timescale 1ns / 1ps

module tb;
    import tmcw_pkg::*;

    // Action code with no effect other than reporting the cursor.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    // Cycles without any transfer before the run is declared hung.
    localparam int WATCHDOG_LIMIT = 20000;
    // Quiet time at the end, longer than a full screen pass.
    localparam int TAIL_CYCLES    = CELLS + 2 * COLUMNS;
    // Length of the receiver hold-off in the backpressure test.
    localparam int HOLD_CYCLES    = 300;
    // Mismatch lines printed before further ones are only counted.
    localparam int PRINT_LIMIT    = 40;

    // Clock and reset.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Block inputs, all known from time zero.
    logic      cfg_valid = 1'b0;
    logic [4:0] cfg_data = '0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;

    // Block outputs.
    logic      o_cfg_ready;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Shadow of the console state.
    logic [15:0] shadow_screen [CELLS] = '{default: '0};
    int unsigned col_now  = 0;
    int unsigned row_now  = 0;
    logic [7:0]  attr_now = ATTR_RESET;
    logic [4:0]  top_row  = '0;

    // Results predicted for accepted items, oldest first.
    t_out_item awaited_reports [$];

    // Traffic shaping.
    int  in_idle_pct   = 0;
    int  out_stall_pct = 0;
    bit  hold_request  = 1'b0;
    int  hold_left     = 0;

    // Run statistics.
    int mismatches      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int scrolls_seen    = 0;
    int reads_seen      = 0;
    int clears_seen     = 0;
    int idle_cycles     = 0;

    text_mode_console_writer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (o_out_data)
    );

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one item to the shadow console and returns the result it should produce.
    function automatic t_out_item console_apply(t_in_item it);
        t_out_item   res;
        int unsigned pos;
        logic [7:0]  b;
        int          r;
        int          c;
        res = '0;
        b   = it.byte_in;
        pos = row_now * COLUMNS + col_now;
        case (it.action)
            ACT_PUT: begin
                if (b >= CH_SPACE && b < CH_DEL) begin
                    shadow_screen[pos] = {attr_now, b};
                    // The following cell takes the attribute too, unless this is the last cell.
                    if (pos + 1 < CELLS) begin
                        shadow_screen[pos + 1][15:8] = attr_now;
                    end
                    col_now++;
                    if (col_now >= COLUMNS) begin
                        row_now++;
                        col_now = 0;
                    end
                end else if (b == CH_LF) begin
                    row_now++;
                    col_now = 0;
                end else if (b == CH_CR) begin
                    col_now = 0;
                end else if (b == CH_TAB) begin
                    col_now += 8 - (col_now % 8);
                    if (col_now >= COLUMNS) begin
                        row_now++;
                        col_now = 0;
                    end
                end else if (b == CH_BS) begin
                    // Backspace at column 0 leaves everything alone.
                    if (col_now > 0) begin
                        col_now--;
                        shadow_screen[pos - 1][7:0] = CH_SPACE;
                    end
                end else if (b >= ATTR_FIRST && b <= ATTR_LAST) begin
                    attr_now = b - ATTR_FIRST;
                end
                // Running off the bottom moves the scroll region up and blanks the last row.
                if (row_now > ROWS - 1) begin
                    for (r = int'(top_row); r < ROWS - 1; r++) begin
                        for (c = 0; c < COLUMNS; c++) begin
                            shadow_screen[r * COLUMNS + c] = shadow_screen[(r + 1) * COLUMNS + c];
                        end
                    end
                    for (c = 0; c < COLUMNS; c++) begin
                        shadow_screen[LAST_ROW_BASE + c] = '0;
                    end
                    row_now = ROWS - 1;
                    scrolls_seen++;
                end
            end
            ACT_READ: begin
                reads_seen++;
                r = int'(it.cell_row);
                c = int'(it.cell_column);
                if (r < ROWS && c < COLUMNS) begin
                    res.read_character = shadow_screen[r * COLUMNS + c][7:0];
                    res.read_attribute = shadow_screen[r * COLUMNS + c][15:8];
                end
            end
            ACT_CLEAR: begin
                // The current attribute survives a clear.
                foreach (shadow_screen[i]) begin
                    shadow_screen[i] = '0;
                end
                row_now = 0;
                col_now = 0;
                clears_seen++;
            end
            default: begin
            end
        endcase
        res.cursor_position = 11'(row_now * COLUMNS + col_now);
        return res;
    endfunction

    // Put item with random don't-care fields.
    function automatic t_in_item put_item(logic [7:0] b);
        t_in_item it;
        it             = '0;
        it.action      = ACT_PUT;
        it.byte_in     = b;
        it.cell_row    = 5'($urandom);
        it.cell_column = 7'($urandom);
        return it;
    endfunction

    // Read item with a random, ignored byte.
    function automatic t_in_item read_item(logic [4:0] row, logic [6:0] col);
        t_in_item it;
        it             = '0;
        it.action      = ACT_READ;
        it.byte_in     = 8'($urandom);
        it.cell_row    = row;
        it.cell_column = col;
        return it;
    endfunction

    function automatic logic [7:0] random_printable();
        return 8'($urandom_range(int'(CH_SPACE), int'(CH_DEL) - 1));
    endfunction

    // Console-like traffic: mostly text and cursor control, some reads, rare clears.
    function automatic t_in_item random_console_item();
        t_in_item    it;
        int unsigned pick;
        it   = put_item(8'($urandom));
        pick = $urandom_range(99);
        if (pick < 55) begin
            it.byte_in = random_printable();
        end else if (pick < 63) begin
            it.byte_in = CH_LF;
        end else if (pick < 67) begin
            it.byte_in = CH_CR;
        end else if (pick < 72) begin
            it.byte_in = CH_TAB;
        end else if (pick < 77) begin
            it.byte_in = CH_BS;
        end else if (pick < 81) begin
            it.byte_in = ATTR_FIRST + 8'($urandom_range(0, 15));
        end else if (pick < 84) begin
            // Keep the fully random byte: ignored controls and high bytes.
        end else if (pick < 97) begin
            it.action = ACT_READ;
            if ($urandom_range(9) >= 2) begin
                // Mostly in range, often on the cursor row where text was just written.
                it.cell_row    = $urandom_range(1) ? 5'(row_now) : 5'($urandom_range(0, ROWS - 1));
                it.cell_column = 7'($urandom_range(0, COLUMNS - 1));
            end
        end else if (pick < 98) begin
            it.action = ACT_CLEAR;
        end else begin
            it.action = ACT_UNUSED;
        end
        return it;
    endfunction

    task automatic set_idling(int in_pct, int out_pct);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
    endtask

    // Offers one item, waits for its transfer and records the predicted result.
    task automatic send_item(t_in_item it);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_reports.push_back(console_apply(it));
        items_sent++;
    endtask

    // Stops offering items and waits for every outstanding result.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(posedge i_clk);
    endtask

    // Writes the scroll top row while the block is idle.
    task automatic write_scroll_top(logic [4:0] top);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= top;
        do @(posedge i_clk); while (!o_cfg_ready);
        top_row = top;
        cfg_valid <= 1'b0;
    endtask

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
                     results_checked, what, got, want);
        end
    endtask

    // Compares one result transfer with the oldest prediction.
    task automatic check_result(t_out_item got);
        t_out_item want;
        if (awaited_reports.size() == 0) begin
            report_mismatch("result with no item outstanding", 32'(got), 0);
            return;
        end
        want = awaited_reports.pop_front();
        if (got.cursor_position !== want.cursor_position) begin
            report_mismatch("cursor_position", 32'(got.cursor_position),
                            32'(want.cursor_position));
        end
        if (got.read_character !== want.read_character) begin
            report_mismatch("read_character", 32'(got.read_character),
                            32'(want.read_character));
        end
        if (got.read_attribute !== want.read_attribute) begin
            report_mismatch("read_attribute", 32'(got.read_attribute),
                            32'(want.read_attribute));
        end
        results_checked++;
    endtask

    // Receiver: checks each result transfer and drives ready, with stalls and hold-offs.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            check_result(o_out_data);
        end
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    // Watchdog on cycles with no transfer on any channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready)
                || (cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, awaited_reports.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Field extremes, every action and the single-step special cases.
    task automatic test_directed();
        set_idling(0, 0);
        send_item(read_item(5'd0, 7'd0));
        send_item(put_item(8'h41));
        send_item(put_item(CH_SPACE));
        send_item(put_item(CH_DEL - 1));
        send_item(put_item(ATTR_FIRST));
        send_item(put_item(8'h42));
        send_item(put_item(ATTR_LAST));
        send_item(put_item(CH_TAB));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_CR));
        send_item(put_item(CH_BS));
        send_item(put_item(CH_LF));
        send_item(put_item(CH_DEL));
        send_item(put_item(8'hff));
        send_item(put_item(8'h00));
        send_item(put_item(8'h0b));
        send_item(read_item(5'd0, 7'd0));
        send_item(read_item(5'd0, 7'd4));
        send_item(read_item(5'd0, 7'd5));
        send_item(read_item(5'(ROWS - 1), 7'(COLUMNS - 1)));
        send_item(read_item(5'h1f, 7'h7f));
        send_item(read_item(5'd0, 7'(COLUMNS)));
        send_item('{action: ACT_UNUSED, byte_in: 8'($urandom),
                    cell_row: 5'($urandom), cell_column: 7'($urandom)});
        send_item('{action: ACT_CLEAR, byte_in: 8'($urandom),
                    cell_row: 5'($urandom), cell_column: 7'($urandom)});
        send_item(read_item(5'd0, 7'd0));
    endtask

    // Runs the cursor off the bottom under several scroll regions.
    task automatic test_scroll_regions();
        logic [4:0] tops [3] = '{5'(ROWS - 1), 5'd0, 5'd7};
        set_idling(35, 35);
        foreach (tops[t]) begin
            write_scroll_top(tops[t]);
            repeat (ROWS + 2) begin
                repeat ($urandom_range(0, 2)) send_item(put_item(random_printable()));
                send_item(put_item(CH_LF));
            end
            if (tops[t] == 0) begin
                // Text up to the very last cell, then a tab that reaches column 80.
                send_item(put_item(CH_CR));
                repeat (9) send_item(put_item(CH_TAB));
                repeat (8) send_item(put_item(random_printable()));
                repeat (10) send_item(put_item(CH_TAB));
                send_item(read_item(5'(ROWS - 2), 7'(COLUMNS - 1)));
                send_item(read_item(5'(ROWS - 2), 7'd72));
                send_item(read_item(5'(ROWS - 1), 7'd0));
            end
            repeat (6) begin
                send_item(read_item(5'($urandom_range(0, ROWS - 1)),
                                    7'($urandom_range(0, COLUMNS - 1))));
            end
        end
    endtask

    // Random console traffic under each idling pattern and scroll setting.
    task automatic test_random_traffic();
        int in_pct  [4] = '{0, 60, 0, 35};
        int out_pct [4] = '{0, 0, 60, 35};
        for (int p = 0; p < 4; p++) begin
            if (p == 0) begin
                write_scroll_top(5'd0);
            end else if (p == 1) begin
                write_scroll_top(5'(ROWS - 1));
            end else begin
                write_scroll_top(5'($urandom_range(1, ROWS - 2)));
            end
            set_idling(in_pct[p], out_pct[p]);
            repeat (50) send_item(random_console_item());
        end
    endtask

    // Receiver holds off for a long stretch while items keep coming.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_request = 1'b1;
        repeat (20) send_item(random_console_item());
        drain_results();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_scroll_regions();
        test_random_traffic();
        test_output_backpressure();

        // Let any stray result show up before the verdict.
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Covered %0d items and %0d results: %0d scrolls, %0d cell reads, %0d clears.",
                 items_sent, results_checked, scrolls_seen, reads_seen, clears_seen);
        $display("Scroll regions from the top row, the middle and the last row; %0d mismatches.",
                 mismatches);
        if (mismatches == 0 && awaited_reports.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
